/* hw/rtl/dtp_pkg.sv */
// ----------------------------------------------------------------------------
// dtp_pkg
// shared types and constants of the disparity reprojection pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package dtp_pkg;

   localparam int unsigned QuotBits = 32;
   localparam int unsigned DenBits  = 47;
   localparam int unsigned RemBits  = DenBits + 1;

   localparam logic [2:0] RegNegCenterX   = 3'd0;
   localparam logic [2:0] RegNegCenterY   = 3'd1;
   localparam logic [2:0] RegFocalLength  = 3'd2;
   localparam logic [2:0] RegInvBaseline  = 3'd3;
   localparam logic [2:0] RegWOffset      = 3'd4;
   localparam logic [2:0] RegMinDisparity = 3'd5;
   localparam logic [2:0] RegMaxDepth     = 3'd6;
   localparam logic [2:0] RegColorEnable  = 3'd7;

   localparam logic [7:0] GrayLevel = 8'd200;

   typedef struct packed {
      logic signed [31:0] neg_center_x;
      logic signed [31:0] neg_center_y;
      logic signed [31:0] focal_length;
      logic signed [31:0] inv_baseline_neg;
      logic signed [31:0] w_offset;
      logic signed [15:0] min_disparity;
      logic        [30:0] max_depth_limit;
      logic               color_enable;
   } cfg_type;

   typedef struct packed {
      logic                neg;
      logic                ovf;
      logic [RemBits-1:0]  rem;
      logic [QuotBits-1:0] dvd;
   } lane_type;

   typedef struct packed {
      logic               valid;
      logic [DenBits-1:0] den;
      lane_type           lx;
      lane_type           ly;
      lane_type           lz;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
   } tok_type;

endpackage

`default_nettype wire

/* hw/rtl/dtp_front.sv */
// ----------------------------------------------------------------------------
// dtp_front
// disparity filter, W product and sum, magnitudes and overflow check
// ----------------------------------------------------------------------------
`default_nettype none

module dtp_front import dtp_pkg::*; #(
   parameter int MaxCols = 4096,
   parameter int MaxRows = 4096
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               adv,
   input  wire logic               in_valid,
   input  wire logic signed [15:0] disparity,
   input  wire logic        [11:0] pixel_x,
   input  wire logic        [11:0] pixel_y,
   input  wire logic        [7:0]  src_blue,
   input  wire logic        [7:0]  src_green,
   input  wire logic        [7:0]  src_red,
   input  wire cfg_type            cfg,
   output tok_type                 tok_out
);

   // stage a
   logic               a_valid_ff, a_valid_in;
   logic signed [47:0] a_prod_ff, a_prod_in;
   logic signed [33:0] a_nx_ff, a_nx_in, a_ny_ff, a_ny_in;
   logic [7:0]         a_r_ff, a_g_ff, a_b_ff, a_r_in, a_g_in, a_b_in;
   logic [11:0]        px_cl, py_cl;

   // stage b
   logic               b_valid_ff;
   logic signed [47:0] b_w_ff, b_w_in;
   logic signed [33:0] b_nx_ff, b_ny_ff;
   logic [7:0]         b_r_ff, b_g_ff, b_b_ff;

   // stage c
   logic               c_valid_ff, c_valid_in;
   logic [DenBits-1:0] c_den_ff, c_den_in;
   lane_type           c_lx_ff, c_ly_ff, c_lz_ff, c_lx_in, c_ly_in, c_lz_in;
   logic [7:0]         c_r_ff, c_g_ff, c_b_ff;
   logic [47:0]        w_mag;

   // stage d
   tok_type            d_tok_ff, d_tok_in;

   function automatic lane_type lane_init(input logic signed [33:0] n, input logic wneg);
      logic [33:0] mag;
      lane_type    l;
      mag   = n[33] ? 34'(-n) : n;
      l.neg = n[33] ^ wneg;
      l.ovf = 1'b0;
      l.rem = {{(RemBits-30){1'b0}}, mag[33:4]};
      l.dvd = {mag[3:0], 28'b0};
      return l;
   endfunction

   always_comb begin
      px_cl = ({5'b0, pixel_x} > 17'(MaxCols - 1)) ? 12'(MaxCols - 1) : pixel_x;
      py_cl = ({5'b0, pixel_y} > 17'(MaxRows - 1)) ? 12'(MaxRows - 1) : pixel_y;
      a_valid_in = in_valid && (disparity >= cfg.min_disparity);
      a_prod_in  = cfg.inv_baseline_neg * disparity;
      a_nx_in    = $signed({6'b0, px_cl, 16'b0})
                 + $signed({{2{cfg.neg_center_x[31]}}, cfg.neg_center_x});
      a_ny_in    = $signed({6'b0, py_cl, 16'b0})
                 + $signed({{2{cfg.neg_center_y[31]}}, cfg.neg_center_y});
      if (cfg.color_enable) begin
         a_r_in = src_red;
         a_g_in = src_green;
         a_b_in = src_blue;
      end else begin
         a_r_in = GrayLevel;
         a_g_in = GrayLevel;
         a_b_in = GrayLevel;
      end
   end

   always_comb begin
      b_w_in = a_prod_ff + $signed({{12{cfg.w_offset[31]}}, cfg.w_offset, 4'b0});
   end

   always_comb begin
      w_mag      = b_w_ff[47] ? 48'(-b_w_ff) : b_w_ff;
      c_valid_in = b_valid_ff && (b_w_ff != 48'sd0);
      c_den_in   = w_mag[DenBits-1:0];
      c_lx_in    = lane_init(b_nx_ff, b_w_ff[47]);
      c_ly_in    = lane_init(b_ny_ff, b_w_ff[47]);
      c_lz_in    = lane_init($signed({{2{cfg.focal_length[31]}}, cfg.focal_length}),
                             b_w_ff[47]);
   end

   always_comb begin
      d_tok_in        = '0;
      d_tok_in.valid  = c_valid_ff;
      d_tok_in.den    = c_den_ff;
      d_tok_in.lx     = c_lx_ff;
      d_tok_in.ly     = c_ly_ff;
      d_tok_in.lz     = c_lz_ff;
      d_tok_in.lx.ovf = c_lx_ff.rem >= {1'b0, c_den_ff};
      d_tok_in.ly.ovf = c_ly_ff.rem >= {1'b0, c_den_ff};
      d_tok_in.lz.ovf = c_lz_ff.rem >= {1'b0, c_den_ff};
      d_tok_in.red    = c_r_ff;
      d_tok_in.green  = c_g_ff;
      d_tok_in.blue   = c_b_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff     <= 1'b0;
         b_valid_ff     <= 1'b0;
         c_valid_ff     <= 1'b0;
         d_tok_ff.valid <= 1'b0;
      end else if (adv) begin
         a_valid_ff     <= a_valid_in;
         b_valid_ff     <= a_valid_ff;
         c_valid_ff     <= c_valid_in;
         d_tok_ff       <= d_tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_prod_ff <= a_prod_in;
         a_nx_ff   <= a_nx_in;
         a_ny_ff   <= a_ny_in;
         a_r_ff    <= a_r_in;
         a_g_ff    <= a_g_in;
         a_b_ff    <= a_b_in;
         b_w_ff    <= b_w_in;
         b_nx_ff   <= a_nx_ff;
         b_ny_ff   <= a_ny_ff;
         b_r_ff    <= a_r_ff;
         b_g_ff    <= a_g_ff;
         b_b_ff    <= a_b_ff;
         c_den_ff  <= c_den_in;
         c_lx_ff   <= c_lx_in;
         c_ly_ff   <= c_ly_in;
         c_lz_ff   <= c_lz_in;
         c_r_ff    <= b_r_ff;
         c_g_ff    <= b_g_ff;
         c_b_ff    <= b_b_ff;
      end
   end

   assign tok_out = d_tok_ff;

endmodule

`default_nettype wire

/* hw/rtl/dtp_div_step.sv */
// ----------------------------------------------------------------------------
// dtp_div_step
// one restoring division bit for the three quotient lanes
// ----------------------------------------------------------------------------
`default_nettype none

module dtp_div_step import dtp_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    adv,
   input  wire tok_type tok_in,
   output tok_type      tok_out
);

   tok_type tok_ff, tok_in_nx;

   function automatic lane_type lane_step(input lane_type l, input logic [DenBits-1:0] den);
      logic [RemBits-1:0] rem2;
      logic               ge;
      lane_type           r;
      rem2  = {l.rem[RemBits-2:0], l.dvd[QuotBits-1]};
      ge    = rem2 >= {1'b0, den};
      r     = l;
      r.rem = ge ? rem2 - {1'b0, den} : rem2;
      r.dvd = {l.dvd[QuotBits-2:0], ge};
      return r;
   endfunction

   always_comb begin
      tok_in_nx    = tok_in;
      tok_in_nx.lx = lane_step(tok_in.lx, tok_in.den);
      tok_in_nx.ly = lane_step(tok_in.ly, tok_in.den);
      tok_in_nx.lz = lane_step(tok_in.lz, tok_in.den);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (adv) begin
         tok_ff <= tok_in_nx;
      end
   end

   assign tok_out = tok_ff;

endmodule

`default_nettype wire

/* hw/rtl/dtp_back.sv */
// ----------------------------------------------------------------------------
// dtp_back
// depth range check, x/y saturation and output register
// ----------------------------------------------------------------------------
`default_nettype none

module dtp_back import dtp_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         adv,
   input  wire tok_type      tok_in,
   input  wire logic [30:0]  max_depth_limit,
   output logic              rsp_valid,
   output logic signed [31:0] rsp_point_x,
   output logic signed [31:0] rsp_point_y,
   output logic [30:0]       rsp_point_z,
   output logic [7:0]        rsp_out_red,
   output logic [7:0]        rsp_out_green,
   output logic [7:0]        rsp_out_blue
);

   logic        valid_ff, valid_in;
   logic [31:0] x_ff, x_in, y_ff, y_in;
   logic [30:0] z_ff;
   logic [7:0]  r_ff, g_ff, b_ff;

   function automatic logic [31:0] sat_q(input lane_type l);
      logic [31:0] res;
      if (!l.neg) begin
         res = (l.ovf || l.dvd[31]) ? 32'h7fff_ffff : l.dvd;
      end else begin
         res = (l.ovf || (l.dvd > 32'h8000_0000)) ? 32'h8000_0000 : 32'(-l.dvd);
      end
      return res;
   endfunction

   always_comb begin
      valid_in = tok_in.valid && !tok_in.lz.neg && !tok_in.lz.ovf
              && (tok_in.lz.dvd != 32'd0)
              && (tok_in.lz.dvd <= {1'b0, max_depth_limit});
      x_in = sat_q(tok_in.lx);
      y_in = sat_q(tok_in.ly);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= tok_in.lz.dvd[30:0];
         r_ff <= tok_in.red;
         g_ff <= tok_in.green;
         b_ff <= tok_in.blue;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_point_x   = x_ff;
   assign rsp_point_y   = y_ff;
   assign rsp_point_z   = z_ff;
   assign rsp_out_red   = r_ff;
   assign rsp_out_green = g_ff;
   assign rsp_out_blue  = b_ff;

endmodule

`default_nettype wire

/* hw/rtl/disparity_to_point_reprojection_top.sv */
// ----------------------------------------------------------------------------
// disparity_to_point_reprojection_top
// disparity pixel to 3D point through a fixed-point Q matrix
//
//   channel  direction  ports
//   req      in         req_valid/req_ready, disparity, pixel x/y, bgr color
//   rsp      out        rsp_valid/rsp_ready, point x/y/z, rgb color
//   csr      in         apb-style register port, 8 registers at 4*i
//
// one beat per cycle while no output beat is held; four front stages, 32 one-bit
// divider stages shared by the x, y and z lanes, one output register.
// dropped pixels leave no beat. reset is synchronous and clears valid bits
// and config registers. a held output beat stalls the whole pipeline, nothing lost.
// ----------------------------------------------------------------------------
`default_nettype none

module disparity_to_point_reprojection_top import dtp_pkg::*; #(
   parameter int MAX_COLS = 4096,
   parameter int MAX_ROWS = 4096
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [15:0] req_disparity,
   input  wire logic        [11:0] req_pixel_x,
   input  wire logic        [11:0] req_pixel_y,
   input  wire logic        [7:0]  req_src_blue,
   input  wire logic        [7:0]  req_src_green,
   input  wire logic        [7:0]  req_src_red,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_point_x,
   output logic signed [31:0]      rsp_point_y,
   output logic        [30:0]      rsp_point_z,
   output logic        [7:0]       rsp_out_red,
   output logic        [7:0]       rsp_out_green,
   output logic        [7:0]       rsp_out_blue,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic        [4:0]  paddr,
   input  wire logic        [31:0] pwdata,
   output logic             [31:0] prdata,
   output logic                    pready
);

   cfg_type cfg_ff;
   logic    adv;
   logic    wr_en;
   tok_type tok [QuotBits+1];

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.neg_center_x     <= '0;
         cfg_ff.neg_center_y     <= '0;
         cfg_ff.focal_length     <= '0;
         cfg_ff.inv_baseline_neg <= '0;
         cfg_ff.w_offset         <= '0;
         cfg_ff.min_disparity    <= 16'sd16;
         cfg_ff.max_depth_limit  <= 31'd655360000;
         cfg_ff.color_enable     <= 1'b1;
      end else if (wr_en) begin
         unique case (paddr[4:2])
            RegNegCenterX:   cfg_ff.neg_center_x     <= pwdata;
            RegNegCenterY:   cfg_ff.neg_center_y     <= pwdata;
            RegFocalLength:  cfg_ff.focal_length     <= pwdata;
            RegInvBaseline:  cfg_ff.inv_baseline_neg <= pwdata;
            RegWOffset:      cfg_ff.w_offset         <= pwdata;
            RegMinDisparity: cfg_ff.min_disparity    <= pwdata[15:0];
            RegMaxDepth:     cfg_ff.max_depth_limit  <= pwdata[30:0];
            RegColorEnable:  cfg_ff.color_enable     <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         RegNegCenterX:   prdata = cfg_ff.neg_center_x;
         RegNegCenterY:   prdata = cfg_ff.neg_center_y;
         RegFocalLength:  prdata = cfg_ff.focal_length;
         RegInvBaseline:  prdata = cfg_ff.inv_baseline_neg;
         RegWOffset:      prdata = cfg_ff.w_offset;
         RegMinDisparity: prdata = {{16{cfg_ff.min_disparity[15]}}, cfg_ff.min_disparity};
         RegMaxDepth:     prdata = {1'b0, cfg_ff.max_depth_limit};
         RegColorEnable:  prdata = {31'b0, cfg_ff.color_enable};
         default:         prdata = '0;
      endcase
   end

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   dtp_front #(
      .MaxCols (MAX_COLS),
      .MaxRows (MAX_ROWS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .disparity (req_disparity),
      .pixel_x   (req_pixel_x),
      .pixel_y   (req_pixel_y),
      .src_blue  (req_src_blue),
      .src_green (req_src_green),
      .src_red   (req_src_red),
      .cfg       (cfg_ff),
      .tok_out   (tok[0])
   );

   for (genvar i = 0; i < QuotBits; i++) begin : g_div
      dtp_div_step u_step (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .tok_in  (tok[i]),
         .tok_out (tok[i+1])
      );
   end

   dtp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .adv             (adv),
      .tok_in          (tok[QuotBits]),
      .max_depth_limit (cfg_ff.max_depth_limit),
      .rsp_valid       (rsp_valid),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_point_z     (rsp_point_z),
      .rsp_out_red     (rsp_out_red),
      .rsp_out_green   (rsp_out_green),
      .rsp_out_blue    (rsp_out_blue)
   );

endmodule

`default_nettype wire
